>>> rtl/core/bitmap_integer_set_macros.svh
// Assertion macros for the checker file of the bitmap set.
`ifndef BITMAP_INTEGER_SET_MACROS_SVH
`define BITMAP_INTEGER_SET_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define BIS_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define BIS_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> rtl/core/bis_pkg.sv
`default_nettype none
package bis_pkg;

  // Capacity
  localparam int SET_WORDS = 32;
  localparam int WORD_BITS = 32;
  localparam int CAP       = SET_WORDS * WORD_BITS;
  localparam int BIT_W     = $clog2(WORD_BITS);
  localparam int WAW       = (SET_WORDS > 1) ? $clog2(SET_WORDS) : 1;
  localparam int CNT_W     = $clog2(CAP + 1);

  // Field widths
  localparam int FUNC_W      = 3;
  localparam int ITEM_W      = 16;
  localparam int WIDX_W      = 5;
  localparam int OTHER_W     = 32;
  localparam int LOWEST_W    = 10;
  localparam int COUNT_W     = 11;
  localparam int IN_TDATA_W  = 56;
  localparam int OUT_TDATA_W = 24;

  // Operation codes
  localparam logic [FUNC_W-1:0] FN_INSERT   = 3'd0;
  localparam logic [FUNC_W-1:0] FN_REMOVE   = 3'd1;
  localparam logic [FUNC_W-1:0] FN_CONTAINS = 3'd2;
  localparam logic [FUNC_W-1:0] FN_CLEAR    = 3'd3;
  localparam logic [FUNC_W-1:0] FN_PICK     = 3'd4;
  localparam logic [FUNC_W-1:0] FN_SUBTRACT = 3'd5;

endpackage
`default_nettype wire

>>> rtl/core/bitmap_integer_set.sv
// Channel     | Dir | Transaction contents
// ------------+-----+---------------------------------------------------------------
// s_axis      | in  | tuser: func; tdata: item_index, word_index, other_word
// m_axis      | out | tdata: member, lowest, empty_res, out_of_range, count
//
// One item at a time; states from acceptance to S_DONE, which hands over the result:
//   insert, remove, contains: S_RMW; subtract: S_RMW, then S_SUB (applies the popcount);
//   pick: S_PICK scans up to the first nonzero word, skipped on an empty set;
//   rejected or spare: none; clear: S_CLEAR (the word store is zeroed one word per cycle).
// After reset the same clearing pass runs before s_axis_tready rises.
// A finished result waits in the output register; the next item is taken meanwhile.
`default_nettype none
module bitmap_integer_set (
  input  wire logic                               clk_i,
  input  wire logic                               rst_ni,
  input  wire logic                               s_axis_tvalid,
  output logic                                    s_axis_tready,
  // [15:0] item_index, [20:16] word_index, [52:21] other_word, [55:53] zero
  input  wire logic [bis_pkg::IN_TDATA_W-1:0]     s_axis_tdata,
  // [2:0] func
  input  wire logic [bis_pkg::FUNC_W-1:0]         s_axis_tuser,
  output logic                                    m_axis_tvalid,
  input  wire logic                               m_axis_tready,
  // [0] member, [10:1] lowest, [11] empty_res, [12] out_of_range, [23:13] count
  output logic [bis_pkg::OUT_TDATA_W-1:0]         m_axis_tdata
);
  import bis_pkg::*;

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_RMW   = 3'd1;
  localparam logic [2:0] S_SUB   = 3'd2;
  localparam logic [2:0] S_PICK  = 3'd3;
  localparam logic [2:0] S_CLEAR = 3'd4;
  localparam logic [2:0] S_DONE  = 3'd5;

  localparam logic [WAW-1:0] LAST_WORD = WAW'(SET_WORDS - 1);

  // Lowest set bit position of a word: isolate it, then encode the one-hot.
  function automatic logic [BIT_W-1:0] first_one(input logic [WORD_BITS-1:0] v);
    logic [WORD_BITS-1:0] iso;
    logic [BIT_W-1:0]     pos;
    iso = v & (~v + WORD_BITS'(1));
    pos = '0;
    for (int k = 0; k < BIT_W; k++) begin
      for (int i = 0; i < WORD_BITS; i++) begin
        if (((i >> k) & 1) == 1) pos[k] = pos[k] | iso[i];
      end
    end
    return pos;
  endfunction

  // Popcount of a word: nibble counts, then a short sum.
  function automatic logic [BIT_W:0] ones(input logic [WORD_BITS-1:0] v);
    logic [2:0]     nib;
    logic [BIT_W:0] tot;
    tot = '0;
    for (int g = 0; g < WORD_BITS / 4; g++) begin
      nib = 3'(v[4*g]) + 3'(v[4*g+1]) + 3'(v[4*g+2]) + 3'(v[4*g+3]);
      tot = tot + (BIT_W+1)'(nib);
    end
    return tot;
  endfunction

  // Control and payload registers
  logic [2:0]             state_q, state_d;
  logic [WAW-1:0]         ptr_q, ptr_d;
  logic [CNT_W-1:0]       cnt_q, cnt_d;
  logic                   pend_q, pend_d;
  logic                   m_valid_q, m_valid_d;
  logic [OUT_TDATA_W-1:0] m_data_q, m_data_d;
  logic [FUNC_W-1:0]      func_q, func_d;
  logic [BIT_W-1:0]       bit_q, bit_d;
  logic [OTHER_W-1:0]     other_q, other_d;
  logic                   member_q, member_d;
  logic                   oor_q, oor_d;
  logic [LOWEST_W-1:0]    lowest_q, lowest_d;
  logic [BIT_W:0]         pop_q, pop_d;

  // Word store
  logic [WORD_BITS-1:0] mem_q [SET_WORDS];
  logic [WORD_BITS-1:0] rdata_q;
  logic                 rd_en, we;
  logic [WAW-1:0]       rd_addr;
  logic [WORD_BITS-1:0] wdata;

  always_ff @(posedge clk_i) begin
    if (we) begin
      mem_q[ptr_q] <= wdata;
    end
    if (rd_en) begin
      rdata_q <= mem_q[rd_addr];
    end
  end

  // Input field split
  logic [ITEM_W-1:0]  in_item;
  logic [WIDX_W-1:0]  in_widx;
  logic [31:0]        item_w32, widx_w32, pick_w32, cnt_w32;
  logic               hit;
  logic [WORD_BITS-1:0] bmask;

  assign in_item  = s_axis_tdata[ITEM_W-1:0];
  assign in_widx  = s_axis_tdata[ITEM_W+WIDX_W-1:ITEM_W];
  assign item_w32 = 32'(in_item[ITEM_W-1:BIT_W]);
  assign widx_w32 = 32'(in_widx);
  assign pick_w32 = 32'({ptr_q, first_one(rdata_q)});
  assign cnt_w32  = 32'(cnt_q);
  assign hit      = rdata_q[bit_q];
  assign bmask    = WORD_BITS'(1) << bit_q;

  assign s_axis_tready = (state_q == S_IDLE);
  assign m_axis_tvalid = m_valid_q;
  assign m_axis_tdata  = m_data_q;

  // Sequencer
  always_comb begin
    state_d   = state_q;
    ptr_d     = ptr_q;
    cnt_d     = cnt_q;
    pend_d    = pend_q;
    m_valid_d = m_valid_q;
    m_data_d  = m_data_q;
    func_d    = func_q;
    bit_d     = bit_q;
    other_d   = other_q;
    member_d  = member_q;
    oor_d     = oor_q;
    lowest_d  = lowest_q;
    pop_d     = pop_q;
    rd_en     = 1'b0;
    rd_addr   = ptr_q;
    we        = 1'b0;
    wdata     = '0;

    if (m_valid_q && m_axis_tready) begin
      m_valid_d = 1'b0;
    end

    case (state_q)
      S_IDLE: begin
        if (s_axis_tvalid) begin
          func_d   = s_axis_tuser;
          bit_d    = in_item[BIT_W-1:0];
          other_d  = s_axis_tdata[ITEM_W+WIDX_W+OTHER_W-1:ITEM_W+WIDX_W];
          member_d = 1'b0;
          oor_d    = 1'b0;
          lowest_d = '0;
          state_d  = S_DONE;
          case (s_axis_tuser)
            FN_INSERT, FN_REMOVE, FN_CONTAINS: begin
              if (item_w32 < SET_WORDS) begin
                ptr_d   = item_w32[WAW-1:0];
                rd_addr = item_w32[WAW-1:0];
                rd_en   = 1'b1;
                state_d = S_RMW;
              end else if (s_axis_tuser == FN_INSERT) begin
                oor_d = 1'b1;
              end
            end
            FN_SUBTRACT: begin
              if (widx_w32 < SET_WORDS) begin
                ptr_d   = widx_w32[WAW-1:0];
                rd_addr = widx_w32[WAW-1:0];
                rd_en   = 1'b1;
                state_d = S_RMW;
              end
            end
            FN_CLEAR: begin
              ptr_d   = '0;
              cnt_d   = '0;
              pend_d  = 1'b1;
              state_d = S_CLEAR;
            end
            FN_PICK: begin
              if (cnt_q != '0) begin
                ptr_d   = '0;
                rd_addr = '0;
                rd_en   = 1'b1;
                state_d = S_PICK;
              end
            end
            default: ;
          endcase
        end
      end

      // Read data is back: modify and write the word
      S_RMW: begin
        state_d = S_DONE;
        case (func_q)
          FN_INSERT: begin
            member_d = hit;
            if (!hit) begin
              we    = 1'b1;
              wdata = rdata_q | bmask;
              cnt_d = cnt_q + CNT_W'(1);
            end
          end
          FN_REMOVE: begin
            member_d = hit;
            if (hit) begin
              we    = 1'b1;
              wdata = rdata_q & ~bmask;
              cnt_d = cnt_q - CNT_W'(1);
            end
          end
          FN_CONTAINS: member_d = hit;
          FN_SUBTRACT: begin
            we      = 1'b1;
            wdata   = rdata_q & ~other_q;
            pop_d   = ones(rdata_q & other_q);
            state_d = S_SUB;
          end
          default: ;
        endcase
      end

      S_SUB: begin
        cnt_d   = cnt_q - CNT_W'(pop_q);
        state_d = S_DONE;
      end

      // One word per cycle until the first nonzero one
      S_PICK: begin
        if (rdata_q != '0) begin
          lowest_d = pick_w32[LOWEST_W-1:0];
          state_d  = S_DONE;
        end else if (ptr_q == LAST_WORD) begin
          state_d = S_DONE;
        end else begin
          ptr_d   = ptr_q + WAW'(1);
          rd_addr = ptr_q + WAW'(1);
          rd_en   = 1'b1;
        end
      end

      // Zero one word per cycle (reset pass and clear operation)
      S_CLEAR: begin
        we = 1'b1;
        if (ptr_q == LAST_WORD) begin
          state_d = pend_q ? S_DONE : S_IDLE;
          pend_d  = 1'b0;
        end else begin
          ptr_d = ptr_q + WAW'(1);
        end
      end

      // Hand the result to the output register once it is free
      S_DONE: begin
        if (!m_valid_q || m_axis_tready) begin
          m_valid_d = 1'b1;
          m_data_d  = {cnt_w32[COUNT_W-1:0], oor_q, (cnt_q == '0), lowest_q, member_q};
          state_d   = S_IDLE;
        end
      end

      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= S_CLEAR;
      ptr_q     <= '0;
      cnt_q     <= '0;
      pend_q    <= 1'b0;
      m_valid_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      ptr_q     <= ptr_d;
      cnt_q     <= cnt_d;
      pend_q    <= pend_d;
      m_valid_q <= m_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    m_data_q <= m_data_d;
    func_q   <= func_d;
    bit_q    <= bit_d;
    other_q  <= other_d;
    member_q <= member_d;
    oor_q    <= oor_d;
    lowest_q <= lowest_d;
    pop_q    <= pop_d;
  end

endmodule
`default_nettype wire

>>> rtl/core/bis_checker.sv
`default_nettype none
`include "bitmap_integer_set_macros.svh"
module bis_checker (
  input wire logic                           clk_i,
  input wire logic                           rst_ni,
  input wire logic                           s_axis_tvalid,
  input wire logic                           s_axis_tready,
  input wire logic [bis_pkg::IN_TDATA_W-1:0] s_axis_tdata,
  input wire logic [bis_pkg::FUNC_W-1:0]     s_axis_tuser,
  input wire logic                           m_axis_tvalid,
  input wire logic                           m_axis_tready,
  input wire logic [bis_pkg::OUT_TDATA_W-1:0] m_axis_tdata
);
  import bis_pkg::*;

  logic                 o_member, o_empty, o_oor;
  logic [LOWEST_W-1:0]  o_lowest;
  logic [COUNT_W-1:0]   o_count;
  logic                 stall;

  assign o_member = m_axis_tdata[0];
  assign o_lowest = m_axis_tdata[LOWEST_W:1];
  assign o_empty  = m_axis_tdata[LOWEST_W+1];
  assign o_oor    = m_axis_tdata[LOWEST_W+2];
  assign o_count  = m_axis_tdata[OUT_TDATA_W-1:LOWEST_W+3];
  assign stall    = m_axis_tvalid && !m_axis_tready;

  // A stalled result stays offered
  `BIS_ASSERT_NEXT(a_out_hold, stall, m_axis_tvalid && $stable(m_axis_tdata), "result dropped or changed under stall")
  // Empty set reports a zero count
  `BIS_ASSERT_NOW(a_empty_count, m_axis_tvalid && o_empty, o_count == '0, "empty with nonzero count")
  // A rejected insert never reports membership or a pick result
  `BIS_ASSERT_NOW(a_oor_clean, m_axis_tvalid && o_oor, !o_member && (o_lowest == '0), "out_of_range mixed with other result")
  // A nonzero lowest member means the set is not empty and no membership is reported
  `BIS_ASSERT_NOW(a_lowest_nonempty, m_axis_tvalid && (o_lowest != '0), !o_empty && !o_member, "lowest reported on empty set")
  // Count never exceeds capacity
  `BIS_ASSERT_NOW(a_count_cap, m_axis_tvalid, (CAP > 2047) || (32'(o_count) <= CAP), "count above capacity")

endmodule

bind bitmap_integer_set bis_checker u_bis_checker (.*);
`default_nettype wire
